[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent followed by consequent (sequence form given by caller)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/tpmc_pkg.sv]
package tpmc_pkg;

  localparam int GRID_SIDE  = 4;
  localparam int GRID_CELLS = 16;
  localparam int PIPE_DEPTH = 4;

  // register indexes
  localparam logic [1:0] REG_GOAL_ROW  = 2'd0;
  localparam logic [1:0] REG_GOAL_COL  = 2'd1;
  localparam logic [1:0] REG_START_ROW = 2'd2;
  localparam logic [1:0] REG_START_COL = 2'd3;

  localparam logic [31:0] ROW_TABLE_RESET = 32'hFFAA5500;
  localparam logic [31:0] COL_TABLE_RESET = 32'hE4E4E4E4;

  // one target layout: row and column of every tile
  typedef struct packed {
    logic [31:0] rows;
    logic [31:0] cols;
  } layout_t;

  function automatic logic [3:0] cell_tile(input logic [63:0] board,
                                           input logic [3:0] pos);
    logic [5:0] lsb;
    lsb = {~pos, 2'b00};
    return board[lsb +: 4];
  endfunction

  function automatic logic [1:0] table_get(input logic [31:0] tab,
                                           input logic [3:0] tile);
    logic [4:0] lsb;
    lsb = {tile, 1'b0};
    return tab[lsb +: 2];
  endfunction

  function automatic logic [1:0] abs_diff(input logic [1:0] a, input logic [1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

[hw/rtl/tpmc_est.sv]
module tpmc_est
  import tpmc_pkg::*;
(
  input  logic        clk,
  input  layout_t     lay,
  input  logic [63:0] board,
  output logic [7:0]  distance
);

  // stage 1: tile lookups per cell
  logic [GRID_CELLS-1:0] s1_nz;
  logic [1:0]            s1_gr [GRID_CELLS];
  logic [1:0]            s1_gc [GRID_CELLS];

  always_ff @(posedge clk) begin
    for (int p = 0; p < GRID_CELLS; p++) begin
      s1_nz[p] <= cell_tile(board, 4'(p)) != 4'd0;
      s1_gr[p] <= table_get(lay.rows, cell_tile(board, 4'(p)));
      s1_gc[p] <= table_get(lay.cols, cell_tile(board, 4'(p)));
    end
  end

  // stage 2: per-cell distance, per-line inversion counts
  logic [2:0]            man [GRID_CELLS];
  logic [GRID_CELLS-1:0] rowm;
  logic [GRID_CELLS-1:0] colm;
  logic [2:0]            rc [GRID_SIDE];
  logic [2:0]            cc [GRID_SIDE];

  always_comb begin
    logic [3:0] pos;
    for (int p = 0; p < GRID_CELLS; p++) begin
      pos     = 4'(p);
      man[p]  = s1_nz[p] ? 3'(abs_diff(pos[3:2], s1_gr[p])) + 3'(abs_diff(pos[1:0], s1_gc[p]))
                         : 3'd0;
      rowm[p] = s1_nz[p] && (s1_gr[p] == pos[3:2]);
      colm[p] = s1_nz[p] && (s1_gc[p] == pos[1:0]);
    end
    for (int l = 0; l < GRID_SIDE; l++) begin
      rc[l] = 3'd0;
      cc[l] = 3'd0;
      for (int a = 0; a < GRID_SIDE; a++) begin
        for (int b = a + 1; b < GRID_SIDE; b++) begin
          if (rowm[l*GRID_SIDE+a] && rowm[l*GRID_SIDE+b] &&
              s1_gc[l*GRID_SIDE+a] > s1_gc[l*GRID_SIDE+b]) begin
            rc[l] = rc[l] + 3'd1;
          end
          if (colm[a*GRID_SIDE+l] && colm[b*GRID_SIDE+l] &&
              s1_gr[a*GRID_SIDE+l] > s1_gr[b*GRID_SIDE+l]) begin
            cc[l] = cc[l] + 3'd1;
          end
        end
      end
    end
  end

  logic [2:0] s2_man [GRID_CELLS];
  logic [2:0] s2_rc  [GRID_SIDE];
  logic [2:0] s2_cc  [GRID_SIDE];

  always_ff @(posedge clk) begin
    s2_man <= man;
    s2_rc  <= rc;
    s2_cc  <= cc;
  end

  // stage 3: row sums of distance, total inversions
  logic [4:0] rsum [GRID_SIDE];
  logic [5:0] conf;

  always_comb begin
    conf = 6'd0;
    for (int r = 0; r < GRID_SIDE; r++) begin
      rsum[r] = 5'(s2_man[r*GRID_SIDE]) + 5'(s2_man[r*GRID_SIDE+1]) +
                5'(s2_man[r*GRID_SIDE+2]) + 5'(s2_man[r*GRID_SIDE+3]);
      conf    = conf + 6'(s2_rc[r]) + 6'(s2_cc[r]);
    end
  end

  logic [4:0] s3_rsum [GRID_SIDE];
  logic [5:0] s3_conf;

  always_ff @(posedge clk) begin
    s3_rsum <= rsum;
    s3_conf <= conf;
  end

  // stage 4: final sum, conflicts weigh two
  always_ff @(posedge clk) begin
    distance <= 8'(s3_rsum[0]) + 8'(s3_rsum[1]) + 8'(s3_rsum[2]) + 8'(s3_rsum[3]) +
                {1'b0, s3_conf, 1'b0};
  end

endmodule

[hw/rtl/tile_puzzle_manhattan_conflict_top.sv]
// channel   direction  handshake                  payload
// request   in         start, busy (busy held low) board
// result    out        done strobe, one cycle      distance_to_goal, distance_to_start
// config    in/out     apb psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// one request per cycle; the result strobes once the request has passed
// the four register stages of each estimator
// busy never rises, so the block takes a request in every cycle
// results cannot be stalled: each shows for one cycle alongside done
// synchronous reset clears the in-flight valid bits and loads both layouts
// with the solved board
module tile_puzzle_manhattan_conflict_top
  import tpmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [63:0] board,
  // result side
  output logic        done,
  output logic [7:0]  distance_to_goal,
  output logic [7:0]  distance_to_start,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // layout tables
  layout_t goal_lay;
  layout_t start_lay;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_lay.rows  <= ROW_TABLE_RESET;
      goal_lay.cols  <= COL_TABLE_RESET;
      start_lay.rows <= ROW_TABLE_RESET;
      start_lay.cols <= COL_TABLE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_GOAL_ROW:  goal_lay.rows  <= pwdata;
        REG_GOAL_COL:  goal_lay.cols  <= pwdata;
        REG_START_ROW: start_lay.rows <= pwdata;
        REG_START_COL: start_lay.cols <= pwdata;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_GOAL_ROW:  prdata = goal_lay.rows;
      REG_GOAL_COL:  prdata = goal_lay.cols;
      REG_START_ROW: prdata = start_lay.rows;
      REG_START_COL: prdata = start_lay.cols;
    endcase
  end

  // the pipeline never backs up
  assign busy = 1'b0;

  // valid bits follow each request through the estimator stages
  logic [PIPE_DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start && !busy};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // one estimator per target layout, same board into both
  tpmc_est u_est_goal (
    .clk      (clk),
    .lay      (goal_lay),
    .board    (board),
    .distance (distance_to_goal)
  );

  tpmc_est u_est_start (
    .clk      (clk),
    .lay      (start_lay),
    .board    (board),
    .distance (distance_to_start)
  );

endmodule

[hw/rtl/tpmc_checker.sv]
`include "assert_macros.svh"

module tpmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [7:0]  distance_to_goal,
  input logic [7:0]  distance_to_start,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // every request yields a result
  `ASSERT_IMPLIES(a_req_done, clk, rst, start && !busy, ##4 done)
  // no result without a matching earlier request
  `ASSERT_IMPLIES(a_done_req, clk, rst, done, $past(start && !busy, 4))
  // a register read right after a write returns the written data
  `ASSERT_IMPLIES(a_readback, clk, rst, psel && penable && pwrite && pready, ##1 (pwrite || paddr[3:2] != $past(paddr[3:2]) || prdata == $past(pwdata)))
  // results stay in range of the largest possible estimate
  `ASSERT_ALWAYS(a_range, clk, rst, !done || (distance_to_goal <= 8'd186 && distance_to_start <= 8'd186))

endmodule

bind tile_puzzle_manhattan_conflict_top tpmc_checker u_tpmc_checker (.*);
